FILE: rtl/ucf_pkg.sv
`default_nettype none
package ucf_pkg;

  // Fraction bits of every fixed-point value.
  localparam int FracBits = 16;
  // Number of register stages from input beat to output register.
  localparam int NumStages = 9;

  // Configuration register indexes.
  localparam logic [2:0] RegMeanDensity = 3'd0;
  localparam logic [2:0] RegSoundSpeed  = 3'd1;
  localparam logic [2:0] RegInvSound    = 3'd2;
  localparam logic [2:0] RegMeanVelX    = 3'd3;
  localparam logic [2:0] RegMeanVelY    = 3'd4;

  typedef logic signed [31:0] q_t;
  typedef logic [NumStages:1] stage_en_t;

  // Nonzero entries of the absolute flux Jacobian.
  typedef struct packed {
    q_t a00;
    q_t a01;
    q_t a02;
    q_t a03;
    q_t a11;
    q_t a12;
    q_t a22;
    q_t a31;
    q_t a32;
    q_t a33;
  } ucf_mat_t;

  localparam q_t QMax = 32'sh7fffffff;
  localparam q_t QMin = 32'sh80000000;

  // Saturate a 34-bit sum to 32 bits.
  function automatic q_t sat34(input logic signed [33:0] v);
    q_t r;
    if (v > 34'sh07fffffff) begin
      r = QMax;
    end else if (v < -34'sh080000000) begin
      r = QMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Fixed-point product, floored, saturated.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    q_t r;
    p = 64'(a) * 64'(b);
    s = p >>> FracBits;
    if (s > 64'(QMax)) begin
      r = QMax;
    end else if (s < 64'(QMin)) begin
      r = QMin;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // Absolute value; the most negative value maps to the largest positive.
  function automatic q_t qabs(input q_t v);
    q_t r;
    if (v == QMin) begin
      r = QMax;
    end else if (v < 0) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Floor of half.
  function automatic q_t qhalf(input q_t v);
    return v >>> 1;
  endfunction

  // Floor of half the exact sum; always fits.
  function automatic q_t qhalf_sum(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ucf_side.sv
`default_nettype none
// Convective flux of one side of the face, with its conservative momentum.
module ucf_side (
  input  wire logic             clk_i,
  input  wire ucf_pkg::stage_en_t en_i,
  input  wire ucf_pkg::q_t      rho_i,
  input  wire ucf_pkg::q_t      vx_i,
  input  wire ucf_pkg::q_t      vy_i,
  input  wire ucf_pkg::q_t      p_i,
  input  wire ucf_pkg::q_t      nx_i,
  input  wire ucf_pkg::q_t      ny_i,
  input  wire ucf_pkg::q_t      rho0_i,
  input  wire ucf_pkg::q_t      c0_i,
  input  wire ucf_pkg::q_t      u0n_i,   // stage 2
  output ucf_pkg::q_t           mom_x_o, // stage 1
  output ucf_pkg::q_t           mom_y_o, // stage 1
  output ucf_pkg::q_t           fl0_o,   // stage 4
  output ucf_pkg::q_t           fl1_o,   // stage 4
  output ucf_pkg::q_t           fl2_o,   // stage 4
  output ucf_pkg::q_t           fl3_o    // stage 6
);
  import ucf_pkg::*;

  q_t vxnx_q1, vyny_q1, c1_q1, c2_q1, pnx_q1, pny_q1, rho_q1, p_q1;
  q_t un_q2, c1_q2, c2_q2, pnx_q2, pny_q2, rho_q2, p_q2;
  q_t r0un_q3, a0_q3, a1_q3, a2_q3, a3_q3, pnx_q3, pny_q3;
  q_t fl0_q4, fl1_q4, fl2_q4, t1_q4, a3_q4;
  q_t t2_q5, a3_q5;
  q_t fl3_q6;

  // Stage 1: products of the raw state.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vxnx_q1 <= qmul(vx_i, nx_i);
      vyny_q1 <= qmul(vy_i, ny_i);
      c1_q1   <= qmul(rho0_i, vx_i);
      c2_q1   <= qmul(rho0_i, vy_i);
      pnx_q1  <= qmul(p_i, nx_i);
      pny_q1  <= qmul(p_i, ny_i);
      rho_q1  <= rho_i;
      p_q1    <= p_i;
    end
  end

  // Stage 2: normal velocity.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      un_q2  <= qadd(vxnx_q1, vyny_q1);
      c1_q2  <= c1_q1;
      c2_q2  <= c2_q1;
      pnx_q2 <= pnx_q1;
      pny_q2 <= pny_q1;
      rho_q2 <= rho_q1;
      p_q2   <= p_q1;
    end
  end

  // Stage 3: advection by the mean normal velocity.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      r0un_q3 <= qmul(rho0_i, un_q2);
      a0_q3   <= qmul(u0n_i, rho_q2);
      a1_q3   <= qmul(u0n_i, c1_q2);
      a2_q3   <= qmul(u0n_i, c2_q2);
      a3_q3   <= qmul(u0n_i, p_q2);
      pnx_q3  <= pnx_q2;
      pny_q3  <= pny_q2;
    end
  end

  // Stage 4: first three flux rows, first sound speed factor.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      fl0_q4 <= qadd(a0_q3, r0un_q3);
      fl1_q4 <= qadd(a1_q3, pnx_q3);
      fl2_q4 <= qadd(a2_q3, pny_q3);
      t1_q4  <= qmul(r0un_q3, c0_i);
      a3_q4  <= a3_q3;
    end
  end

  // Stage 5: second sound speed factor.
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      t2_q5 <= qmul(t1_q4, c0_i);
      a3_q5 <= a3_q4;
    end
  end

  // Stage 6: pressure flux row.
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      fl3_q6 <= qadd(a3_q5, t2_q5);
    end
  end

  assign mom_x_o = c1_q1;
  assign mom_y_o = c2_q1;
  assign fl0_o   = fl0_q4;
  assign fl1_o   = fl1_q4;
  assign fl2_o   = fl2_q4;
  assign fl3_o   = fl3_q6;

endmodule
`default_nettype wire

FILE: rtl/ucf_jac.sv
`default_nettype none
// Absolute flux Jacobian from the mean flow and the face normal.
module ucf_jac (
  input  wire logic               clk_i,
  input  wire ucf_pkg::stage_en_t en_i,
  input  wire ucf_pkg::q_t        nx_i,
  input  wire ucf_pkg::q_t        ny_i,
  input  wire ucf_pkg::q_t        c0_i,
  input  wire ucf_pkg::q_t        inv_c0_i,
  input  wire ucf_pkg::q_t        u0n_i,  // stage 2
  output ucf_pkg::ucf_mat_t       mat_o   // stage 6
);
  import ucf_pkg::*;

  q_t i2c_q, i2c2_q;
  q_t nx_q1, ny_q1, nx2_q1, ny2_q1, nxny_q1, cnx_q1, cny_q1;
  q_t nx_q2, ny_q2, nx2_q2, ny2_q2, nxny_q2, cnx_q2, cny_q2;
  q_t nx_q3, ny_q3, nx2_q3, ny2_q3, nxny_q3, cnx_q3, cny_q3;
  q_t absu_q3, cpu_q3, cmu_q3;
  q_t nx_q4, ny_q4, nx2_q4, ny2_q4, nxny_q4, cnx_q4, cny_q4;
  q_t plus_q4, minus_q4, abs2_q4, absu_q4;
  q_t pm2u_q5, nxm_q5, nym_q5, ny2a_q5, nx2p_q5, nx2a_q5, ny2p_q5;
  q_t p31_q5, p32_q5, a33_q5, absu_q5, nxny_q5;
  ucf_mat_t mat_q6;

  // Terms that follow from configuration alone; settled while idle.
  always_ff @(posedge clk_i) begin
    i2c_q  <= qhalf(inv_c0_i);
    i2c2_q <= qhalf(qmul(inv_c0_i, inv_c0_i));
  end

  // Stage 1: normal products.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      nx_q1   <= nx_i;
      ny_q1   <= ny_i;
      nx2_q1  <= qmul(nx_i, nx_i);
      ny2_q1  <= qmul(ny_i, ny_i);
      nxny_q1 <= qmul(nx_i, ny_i);
      cnx_q1  <= qmul(c0_i, nx_i);
      cny_q1  <= qmul(c0_i, ny_i);
    end
  end

  // Stage 2: wait for the mean normal velocity.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      nx_q2   <= nx_q1;
      ny_q2   <= ny_q1;
      nx2_q2  <= nx2_q1;
      ny2_q2  <= ny2_q1;
      nxny_q2 <= nxny_q1;
      cnx_q2  <= cnx_q1;
      cny_q2  <= cny_q1;
    end
  end

  // Stage 3: wave speeds c+u and c-u.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      absu_q3 <= qabs(u0n_i);
      cpu_q3  <= qabs(qadd(c0_i, u0n_i));
      cmu_q3  <= qabs(qsub(c0_i, u0n_i));
      nx_q3   <= nx_q2;
      ny_q3   <= ny_q2;
      nx2_q3  <= nx2_q2;
      ny2_q3  <= ny2_q2;
      nxny_q3 <= nxny_q2;
      cnx_q3  <= cnx_q2;
      cny_q3  <= cny_q2;
    end
  end

  // Stage 4: sum and difference of the acoustic speeds.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      plus_q4  <= qadd(cmu_q3, cpu_q3);
      minus_q4 <= qsub(cpu_q3, cmu_q3);
      abs2_q4  <= qadd(absu_q3, absu_q3);
      absu_q4  <= absu_q3;
      nx_q4    <= nx_q3;
      ny_q4    <= ny_q3;
      nx2_q4   <= nx2_q3;
      ny2_q4   <= ny2_q3;
      nxny_q4  <= nxny_q3;
      cnx_q4   <= cnx_q3;
      cny_q4   <= cny_q3;
    end
  end

  // Stage 5: first products of the matrix entries.
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      pm2u_q5 <= qsub(plus_q4, abs2_q4);
      nxm_q5  <= qmul(nx_q4, minus_q4);
      nym_q5  <= qmul(ny_q4, minus_q4);
      ny2a_q5 <= qmul(ny2_q4, absu_q4);
      nx2p_q5 <= qmul(nx2_q4, plus_q4);
      nx2a_q5 <= qmul(nx2_q4, absu_q4);
      ny2p_q5 <= qmul(ny2_q4, plus_q4);
      p31_q5  <= qmul(cnx_q4, minus_q4);
      p32_q5  <= qmul(cny_q4, minus_q4);
      a33_q5  <= qhalf(plus_q4);
      absu_q5 <= absu_q4;
      nxny_q5 <= nxny_q4;
    end
  end

  // Stage 6: finished entries.
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      mat_q6.a00 <= absu_q5;
      mat_q6.a01 <= qmul(nxm_q5, i2c_q);
      mat_q6.a02 <= qmul(nym_q5, i2c_q);
      mat_q6.a03 <= qmul(pm2u_q5, i2c2_q);
      mat_q6.a11 <= qadd(ny2a_q5, qhalf(nx2p_q5));
      mat_q6.a12 <= qhalf(qmul(nxny_q5, pm2u_q5));
      mat_q6.a22 <= qadd(nx2a_q5, qhalf(ny2p_q5));
      mat_q6.a31 <= qhalf(p31_q5);
      mat_q6.a32 <= qhalf(p32_q5);
      mat_q6.a33 <= a33_q5;
    end
  end

  assign mat_o = mat_q6;

endmodule
`default_nettype wire

FILE: rtl/upwind_cir_face_flux_top.sv
`default_nettype none
// Channel   | Dir | Beat contents
// s_axis    | in  | left and right state, face normal
// m_axis    | out | four flux components and signal speed
// cfg       | in  | mean flow register write, no wait
//
// Nine register stages; one face per clock when the output is taken.
// An accepted beat moves through the stages in order and ends in the output
// register, stage 9, from which it is taken; a stall holds it in place.
// Each stage holds when it is full and the next stage holds, so bubbles close up.
// Reset clears the stage valid bits and loads the register defaults.
module upwind_cir_face_flux_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // left_density, left_vel_x, left_vel_y, left_press, right_density,
  // right_vel_x, right_vel_y, right_press, normal_x, normal_y, zero pad
  input  wire logic [295:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // flux_mass, flux_mom_x, flux_mom_y, flux_energy, signal_speed, zero pad
  output logic [159:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  import ucf_pkg::*;

  logic [30:0] rho0_q, c0_q, inv_c0_q;
  q_t mvx_q, mvy_q, rho0, c0, inv_c0;

  logic [NumStages:1] valid_q;
  stage_en_t en;

  q_t l_rho, l_vx, l_vy, l_p, r_rho, r_vx, r_vy, r_p, nx, ny;
  q_t mx_q1, my_q1, du0_q1, du3_q1, u0n_q2;
  q_t l_mx, l_my, r_mx, r_my;
  q_t l_fl0, l_fl1, l_fl2, l_fl3, r_fl0, r_fl1, r_fl2, r_fl3;
  q_t du_q [2:6][4];
  q_t avg_q [5:8][4];
  logic [30:0] ws_q [3:9];
  logic [32:0] ws_sum;
  ucf_mat_t mat;
  q_t pr_q [4][4];
  q_t d_q [4];
  q_t out_q [4];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho0_q   <= 31'd65536;
      c0_q     <= 31'd65536;
      inv_c0_q <= 31'd65536;
      mvx_q    <= '0;
      mvy_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMeanDensity: rho0_q   <= cfg_data_i[30:0];
        RegSoundSpeed:  c0_q     <= cfg_data_i[30:0];
        RegInvSound:    inv_c0_q <= cfg_data_i[30:0];
        RegMeanVelX:    mvx_q    <= cfg_data_i;
        RegMeanVelY:    mvy_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rho0   = {1'b0, rho0_q};
  assign c0     = {1'b0, c0_q};
  assign inv_c0 = {1'b0, inv_c0_q};

  // Stage handshake: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[NumStages] = !valid_q[NumStages] || m_axis_tready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k - 1];
        end
      end
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = valid_q[NumStages];

  // Input beat unpacking.
  assign l_rho = s_axis_tdata[31:0];
  assign l_vx  = s_axis_tdata[63:32];
  assign l_vy  = s_axis_tdata[95:64];
  assign l_p   = s_axis_tdata[127:96];
  assign r_rho = s_axis_tdata[159:128];
  assign r_vx  = s_axis_tdata[191:160];
  assign r_vy  = s_axis_tdata[223:192];
  assign r_p   = s_axis_tdata[255:224];
  assign nx    = {{14{s_axis_tdata[273]}}, s_axis_tdata[273:256]};
  assign ny    = {{14{s_axis_tdata[291]}}, s_axis_tdata[291:274]};

  ucf_side u_left (
    .clk_i, .en_i(en),
    .rho_i(l_rho), .vx_i(l_vx), .vy_i(l_vy), .p_i(l_p),
    .nx_i(nx), .ny_i(ny), .rho0_i(rho0), .c0_i(c0), .u0n_i(u0n_q2),
    .mom_x_o(l_mx), .mom_y_o(l_my),
    .fl0_o(l_fl0), .fl1_o(l_fl1), .fl2_o(l_fl2), .fl3_o(l_fl3)
  );

  ucf_side u_right (
    .clk_i, .en_i(en),
    .rho_i(r_rho), .vx_i(r_vx), .vy_i(r_vy), .p_i(r_p),
    .nx_i(nx), .ny_i(ny), .rho0_i(rho0), .c0_i(c0), .u0n_i(u0n_q2),
    .mom_x_o(r_mx), .mom_y_o(r_my),
    .fl0_o(r_fl0), .fl1_o(r_fl1), .fl2_o(r_fl2), .fl3_o(r_fl3)
  );

  ucf_jac u_jac (
    .clk_i, .en_i(en),
    .nx_i(nx), .ny_i(ny), .c0_i(c0), .inv_c0_i(inv_c0), .u0n_i(u0n_q2),
    .mat_o(mat)
  );

  // Stages 1 and 2: mean normal velocity and the state jump.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mx_q1  <= qmul(mvx_q, nx);
      my_q1  <= qmul(mvy_q, ny);
      du0_q1 <= qsub(r_rho, l_rho);
      du3_q1 <= qsub(r_p, l_p);
    end
    if (en[2]) begin
      u0n_q2     <= qadd(mx_q1, my_q1);
      du_q[2][0] <= du0_q1;
      du_q[2][1] <= qsub(r_mx, l_mx);
      du_q[2][2] <= qsub(r_my, l_my);
      du_q[2][3] <= du3_q1;
    end
    for (int k = 3; k <= 6; k++) begin
      if (en[k]) begin
        du_q[k] <= du_q[k - 1];
      end
    end
  end

  // Signal speed, saturated to 31 bits, then carried along.
  assign ws_sum = {1'b0, qabs(u0n_q2)} + {2'b00, c0_q};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ws_q[3] <= (ws_sum[32] || ws_sum[31]) ? 31'h7fffffff : ws_sum[30:0];
    end
    for (int k = 4; k <= 9; k++) begin
      if (en[k]) begin
        ws_q[k] <= ws_q[k - 1];
      end
    end
  end

  // Averages of the two convective fluxes.
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      avg_q[5][0] <= qhalf_sum(l_fl0, r_fl0);
      avg_q[5][1] <= qhalf_sum(l_fl1, r_fl1);
      avg_q[5][2] <= qhalf_sum(l_fl2, r_fl2);
      avg_q[5][3] <= '0;
    end
    if (en[6]) begin
      avg_q[6] <= avg_q[5];
    end
    if (en[7]) begin
      avg_q[7][0] <= avg_q[6][0];
      avg_q[7][1] <= avg_q[6][1];
      avg_q[7][2] <= avg_q[6][2];
      avg_q[7][3] <= qhalf_sum(l_fl3, r_fl3);
    end
    if (en[8]) begin
      avg_q[8] <= avg_q[7];
    end
  end

  // Stage 7: Jacobian times the jump, one product per entry.
  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      pr_q[0][0] <= qmul(mat.a00, du_q[6][0]);
      pr_q[0][1] <= qmul(mat.a01, du_q[6][1]);
      pr_q[0][2] <= qmul(mat.a02, du_q[6][2]);
      pr_q[0][3] <= qmul(mat.a03, du_q[6][3]);
      pr_q[1][0] <= '0;
      pr_q[1][1] <= qmul(mat.a11, du_q[6][1]);
      pr_q[1][2] <= qmul(mat.a12, du_q[6][2]);
      pr_q[1][3] <= qmul(mat.a01, du_q[6][3]);
      pr_q[2][0] <= '0;
      pr_q[2][1] <= qmul(mat.a12, du_q[6][1]);
      pr_q[2][2] <= qmul(mat.a22, du_q[6][2]);
      pr_q[2][3] <= qmul(mat.a02, du_q[6][3]);
      pr_q[3][0] <= '0;
      pr_q[3][1] <= qmul(mat.a31, du_q[6][1]);
      pr_q[3][2] <= qmul(mat.a32, du_q[6][2]);
      pr_q[3][3] <= qmul(mat.a33, du_q[6][3]);
    end
  end

  // Stage 8: row sums; stage 9: upwind correction into the output register.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      if (en[8]) begin
        d_q[i] <= sat34(34'(pr_q[i][0]) + 34'(pr_q[i][1]) +
                        34'(pr_q[i][2]) + 34'(pr_q[i][3]));
      end
      if (en[9]) begin
        out_q[i] <= qsub(avg_q[8][i], qhalf(d_q[i]));
      end
    end
  end

  assign m_axis_tdata = {1'b0, ws_q[9], out_q[3], out_q[2], out_q[1], out_q[0]};

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import ucf_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int ItemsPerPhase = 165;
  localparam int NumPhases = 8;

  typedef struct {
    int st[8];
    int nx;
    int ny;
  } face_t;

  typedef struct {
    int mass;
    int mom_x;
    int mom_y;
    int energy;
    int speed;
  } flux_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [295:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  upwind_cir_face_flux_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report(input string what, input int got, input int want);
    error_count++;
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Flux predictor and queue of expected output beats.
  class flux_board;
    int rho0 = 65536;
    int c0 = 65536;
    int inv_c = 65536;
    int u0x = 0;
    int u0y = 0;
    flux_t expected_fluxes[$];

    function int sat(longint v);
      if (v > 64'sh7fffffff) return 32'h7fffffff;
      if (v < -64'sh80000000) return 32'h80000000;
      return int'(v);
    endfunction

    // Fixed-point product, floored, saturated.
    function int qm(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat(p >>> FracBits);
    endfunction

    function int qa(int v);
      if (v == 32'h80000000) return 32'h7fffffff;
      return v < 0 ? -v : v;
    endfunction

    function longint hf(longint v);
      return v >>> 1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        RegMeanDensity: rho0 = int'({1'b0, val[30:0]});
        RegSoundSpeed:  c0 = int'({1'b0, val[30:0]});
        RegInvSound:    inv_c = int'({1'b0, val[30:0]});
        RegMeanVelX:    u0x = int'(val);
        RegMeanVelY:    u0y = int'(val);
        default: ;
      endcase
    endfunction

    // Convective flux of one side and its conservative vector.
    function void side(input int s0, s1, s2, s3, nx, ny, u0n,
                       output int cons[4], output int fl[4]);
      int un;
      int r0un;
      un = sat(longint'(qm(s1, nx)) + qm(s2, ny));
      r0un = qm(rho0, un);
      cons[0] = s0;
      cons[1] = qm(rho0, s1);
      cons[2] = qm(rho0, s2);
      cons[3] = s3;
      fl[0] = sat(longint'(qm(u0n, cons[0])) + r0un);
      fl[1] = sat(longint'(qm(u0n, cons[1])) + qm(s3, nx));
      fl[2] = sat(longint'(qm(u0n, cons[2])) + qm(s3, ny));
      fl[3] = sat(longint'(qm(u0n, cons[3])) + qm(qm(r0un, c0), c0));
    endfunction

    function void note_face(face_t f);
      int lc[4], rc[4], lf[4], rf[4], du[4], res[4];
      int a[4][4];
      int u0n, au, cpu, cmu, pl, mi, pm2u, i2c, i2c2, nx2, ny2, nxny, t;
      longint acc;
      longint ws;
      flux_t r;
      u0n = sat(longint'(qm(u0x, f.nx)) + qm(u0y, f.ny));
      side(f.st[0], f.st[1], f.st[2], f.st[3], f.nx, f.ny, u0n, lc, lf);
      side(f.st[4], f.st[5], f.st[6], f.st[7], f.nx, f.ny, u0n, rc, rf);
      for (int i = 0; i < 4; i++) du[i] = sat(longint'(rc[i]) - lc[i]);
      au = qa(u0n);
      cpu = qa(sat(longint'(c0) + u0n));
      cmu = qa(sat(longint'(c0) - u0n));
      pl = sat(longint'(cmu) + cpu);
      mi = sat(longint'(cpu) - cmu);
      pm2u = sat(longint'(pl) - sat(2 * longint'(au)));
      i2c = int'(hf(inv_c));
      i2c2 = sat(hf(qm(inv_c, inv_c)));
      nx2 = qm(f.nx, f.nx);
      ny2 = qm(f.ny, f.ny);
      nxny = qm(f.nx, f.ny);
      // Absolute flux Jacobian, built from the mean flow only.
      a[0][0] = au;
      a[0][1] = qm(qm(f.nx, mi), i2c);
      a[0][2] = qm(qm(f.ny, mi), i2c);
      a[0][3] = qm(pm2u, i2c2);
      a[1][0] = 0;
      a[1][1] = sat(longint'(qm(ny2, au)) + hf(qm(nx2, pl)));
      t = sat(hf(qm(nxny, pm2u)));
      a[1][2] = t;
      a[1][3] = a[0][1];
      a[2][0] = 0;
      a[2][1] = t;
      a[2][2] = sat(longint'(qm(nx2, au)) + hf(qm(ny2, pl)));
      a[2][3] = a[0][2];
      a[3][0] = 0;
      a[3][1] = sat(hf(qm(qm(c0, f.nx), mi)));
      a[3][2] = sat(hf(qm(qm(c0, f.ny), mi)));
      a[3][3] = sat(hf(pl));
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) acc += qm(a[i][j], du[j]);
        res[i] = sat(longint'(sat(hf(longint'(lf[i]) + rf[i]))) - hf(sat(acc)));
      end
      ws = longint'(au) + c0;
      if (ws > 64'sh7fffffff) ws = 64'sh7fffffff;
      r.mass = res[0];
      r.mom_x = res[1];
      r.mom_y = res[2];
      r.energy = res[3];
      r.speed = int'(ws);
      expected_fluxes.push_back(r);
    endfunction

    task check(logic [159:0] d);
      flux_t e;
      if (expected_fluxes.size() == 0) begin
        report("unexpected beat", int'(d[31:0]), 0);
        return;
      end
      e = expected_fluxes.pop_front();
      if (int'(d[31:0]) != e.mass) report("flux_mass", int'(d[31:0]), e.mass);
      if (int'(d[63:32]) != e.mom_x) report("flux_mom_x", int'(d[63:32]), e.mom_x);
      if (int'(d[95:64]) != e.mom_y) report("flux_mom_y", int'(d[95:64]), e.mom_y);
      if (int'(d[127:96]) != e.energy) report("flux_energy", int'(d[127:96]), e.energy);
      if (int'({1'b0, d[158:128]}) != e.speed)
        report("signal_speed", int'({1'b0, d[158:128]}), e.speed);
      if (d[159] !== 1'b0) report("pad bit", int'(d[159]), 0);
    endtask

    function int pending();
      return expected_fluxes.size();
    endfunction
  endclass

  flux_board board = new;

  // Output side: check accepted beats, stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check(m_tdata);
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one face, with a random gap first, and wait for acceptance.
  task automatic send_face(input face_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < 8; i++) s_tdata[32*i +: 32] <= f.st[i];
    s_tdata[273:256] <= f.nx[17:0];
    s_tdata[291:274] <= f.ny[17:0];
    s_tdata[295:292] <= '0;
    do @(posedge clk_i); while (!s_tready);
    board.note_face(f);
  endtask

  // Stop sending and let the pipeline drain.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (NumStages + 3) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int v[5]);
    logic [2:0] idx[5];
    idx = '{RegMeanDensity, RegSoundSpeed, RegInvSound, RegMeanVelX, RegMeanVelY};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= v[i];
      @(posedge clk_i);
      board.write_reg(idx[i], v[i]);
    end
    // An unknown index must leave the registers alone.
    cfg_idx <= RegUnused;
    cfg_data <= $urandom;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_q();
    int pick[5];
    pick = '{32'h7fffffff, 32'h80000000, 0, -1, 1};
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return pick[$urandom_range(4)];
      default: return int'($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  function automatic int rand_normal();
    int pick[5];
    pick = '{65536, -65536, 0, 46341, -46341};
    if ($urandom_range(1)) return pick[$urandom_range(4)];
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  function automatic face_t rand_face();
    face_t f;
    for (int i = 0; i < 8; i++) f.st[i] = rand_q();
    f.nx = rand_normal();
    f.ny = rand_normal();
    return f;
  endfunction

  function automatic face_t flat_face(int v, int nx, int ny);
    face_t f;
    for (int i = 0; i < 8; i++) f.st[i] = v;
    f.nx = nx;
    f.ny = ny;
    return f;
  endfunction

  initial begin
    int cfgs[6][5];
    int idle[4][2];
    face_t f;
    cfgs[0] = '{65536, 65536, 65536, 0, 0};
    cfgs[1] = '{78643, 340 << 16, 193, 50 << 16, -(30 << 16)};
    cfgs[2] = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    cfgs[3] = '{1, 1, 1, 32'h80000000, 32'h7fffffff};
    cfgs[4] = '{2 << 16, 2 << 16, 3 << 16, -(1 << 16), 1 << 15};
    idle = '{'{0, 0}, '{54, 0}, '{0, 54}, '{21, 21}};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed faces under the reset registers.
    send_face(flat_face(0, 65536, 0));
    send_face(flat_face(32'h7fffffff, 65536, 65536));
    send_face(flat_face(32'h80000000, -65536, -65536));
    send_face(flat_face(-1, 0, -65536));
    send_face(flat_face(1 << 16, 46341, 46341));
    f = flat_face(32'h7fffffff, -65536, 65536);
    for (int i = 0; i < 4; i++) f.st[i] = 32'h80000000;
    send_face(f);
    f = flat_face(32'h80000000, 65536, -65536);
    for (int i = 0; i < 4; i++) f.st[i] = 32'h7fffffff;
    send_face(f);
    drain();
    // Signal speed overflow and the other extremes of the mean flow.
    for (int c = 2; c <= 4; c++) begin
      write_cfg(cfgs[c]);
      send_face(flat_face(32'h7fffffff, 65536, 65536));
      send_face(flat_face(32'h80000000, -65536, 65536));
      send_face(flat_face(3 << 16, 0, 0));
      send_face(rand_face());
      drain();
    end

    // Random faces across register settings and idle patterns.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 5) begin
        write_cfg(cfgs[p]);
      end else begin
        cfgs[5] = '{$urandom_range(1, 32'h7fffffff) | ($urandom << 31),
                    $urandom_range(1, 32'h7fffffff) | ($urandom << 31),
                    $urandom_range(1, 32'h7fffffff), $urandom, $urandom};
        write_cfg(cfgs[5]);
      end
      send_idle_pct = idle[p % 4][0];
      recv_stall_pct = idle[p % 4][1];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_face(rand_face());
        // In phase 2 only, hold off mid-phase until every result is back.
        if (p == 2 && n == ItemsPerPhase / 2) drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (error_count == 0 && board.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
